// ===== rtl/core/hmvt_pkg.sv =====
package hmvt_pkg;

   // fixed-point format of every element and vector component
   localparam int FRAC_BITS = 16;
   localparam int FIX_W     = 32;

   // matrix storage: four columns, two registers each
   localparam int NUM_COLS  = 4;
   localparam int NUM_REGS  = 2 * NUM_COLS;
   localparam int REG_W     = 2 * FIX_W;
   localparam int REG_IDX_W = $clog2(NUM_REGS);

   // datapath widths: full product, pair sum, four-term sum
   localparam int PROD_W = 2 * FIX_W;
   localparam int PAIR_W = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;

   // top bit of the kept result; all bits from here up must agree
   localparam int SAT_LSB = FRAC_BITS + FIX_W - 1;

   localparam logic [FIX_W-1:0] FIX_MAX = {1'b0, {(FIX_W-1){1'b1}}};
   localparam logic [FIX_W-1:0] FIX_MIN = {1'b1, {(FIX_W-1){1'b0}}};

   // reset matrix is the identity
   localparam logic [REG_W-1:0] ONE_LO = REG_W'(1) << FRAC_BITS;
   localparam logic [REG_W-1:0] ONE_HI = ONE_LO << FIX_W;
   localparam logic [NUM_REGS-1:0][REG_W-1:0] CFG_RESET = '{
      ONE_HI, '0,       // t_zw, t_xy
      ONE_LO, '0,       // k_zw, k_xy
      '0,     ONE_HI,   // j_zw, j_xy
      '0,     ONE_LO    // i_zw, i_xy
   };

   typedef logic [NUM_COLS-1:0][FIX_W-1:0] fix_vec_type;

   // per-stage load enables handed to each lane
   typedef struct packed {
      logic prod_en;
      logic pair_en;
      logic sum_en;
   } hmvt_lane_en_type;

endpackage

// ===== rtl/core/hmvt_if.sv =====
// input vector channel
interface hmvt_req_if;
   import hmvt_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [FIX_W-1:0] in_x;
   logic signed [FIX_W-1:0] in_y;
   logic signed [FIX_W-1:0] in_z;
   logic signed [FIX_W-1:0] in_w;

   modport source (output valid, in_x, in_y, in_z, in_w, input ready);
   modport sink   (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

// transformed vector channel
interface hmvt_rsp_if;
   import hmvt_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [FIX_W-1:0] out_x;
   logic signed [FIX_W-1:0] out_y;
   logic signed [FIX_W-1:0] out_z;
   logic signed [FIX_W-1:0] out_w;
   logic                    overflowed;

   modport source (output valid, out_x, out_y, out_z, out_w, overflowed, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_w, overflowed, output ready);
endinterface

// ===== rtl/core/homogeneous_matrix_vector_transform_top.sv =====
// Transforms one (x, y, z, w) vector in signed Q16.16 per beat by a 4x4 matrix
// held in eight 64-bit registers (I, J, K and translation columns, x/z element
// in the low word, y/w in the high word; reset gives the identity). Each output
// component is the exact sum of four 64-bit products, shifted right by 16 bits
// with rounding toward minus infinity and clamped to 32 bits; overflowed flags
// any clamped component. Four lanes, one per output component, run a three-stage
// multiply and adder tree, then one clamp stage drives the result register: a
// beat is accepted every cycle unless the output stalls. Each stage moves on
// when the next one is free, so bubbles close up under a stalled output. Write
// the registers only while no beat is in flight.
module homogeneous_matrix_vector_transform_top import hmvt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   hmvt_req_if.sink             req_if,
   hmvt_rsp_if.source           rsp_if,
   input  logic                 csr_wr_en,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   logic [NUM_REGS-1:0][REG_W-1:0] cfg_ff;
   logic [NUM_REGS-1:0][REG_W-1:0] cfg_in;

   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic v1_in, v2_in, v3_in, vo_in;
   logic en1, en2, en3, en_out;

   hmvt_lane_en_type        lane_en;
   fix_vec_type             vec;
   fix_vec_type             elem [NUM_COLS];
   logic signed [SUM_W-1:0] lane_sum [NUM_COLS];
   fix_vec_type             comp;
   logic                    ovf;

   // matrix registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         cfg_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stage enables: a stage loads when it is empty or its contents move on
   assign en_out = !vo_ff || rsp_if.ready;
   assign en3    = !v3_ff || en_out;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;

   assign v1_in = en1    ? req_if.valid : v1_ff;
   assign v2_in = en2    ? v1_ff        : v2_ff;
   assign v3_in = en3    ? v2_ff        : v3_ff;
   assign vo_in = en_out ? v3_ff        : vo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         vo_ff <= vo_in;
      end
   end

   assign req_if.ready = en1;

   assign lane_en.prod_en = en1;
   assign lane_en.pair_en = en2;
   assign lane_en.sum_en  = en3;

   // incoming beat as a component vector
   assign vec[0] = req_if.in_x;
   assign vec[1] = req_if.in_y;
   assign vec[2] = req_if.in_z;
   assign vec[3] = req_if.in_w;

   // one lane per output row; lane r sees row r of every column
   for (genvar r = 0; r < NUM_COLS; r++) begin : g_lane
      for (genvar c = 0; c < NUM_COLS; c++) begin : g_elem
         assign elem[r][c] = cfg_ff[(c << 1) | (r >> 1)][(r & 1) * FIX_W +: FIX_W];
      end

      hmvt_lane u_lane (
         .clock (clock),
         .en    (lane_en),
         .elem  (elem[r]),
         .vec   (vec),
         .sum   (lane_sum[r])
      );
   end

   // clamp and combine lanes into the result register
   hmvt_merge u_merge (
      .clock      (clock),
      .load       (en_out),
      .sum        (lane_sum),
      .comp       (comp),
      .overflowed (ovf)
   );

   assign rsp_if.valid      = vo_ff;
   assign rsp_if.out_x      = $signed(comp[0]);
   assign rsp_if.out_y      = $signed(comp[1]);
   assign rsp_if.out_z      = $signed(comp[2]);
   assign rsp_if.out_w      = $signed(comp[3]);
   assign rsp_if.overflowed = ovf;

endmodule

// ===== rtl/core/hmvt_lane.sv =====
module hmvt_lane import hmvt_pkg::*; (
   input  logic                    clock,
   input  hmvt_lane_en_type        en,
   input  fix_vec_type             elem,
   input  fix_vec_type             vec,
   output logic signed [SUM_W-1:0] sum
);

   logic signed [PROD_W-1:0] prod_ff [NUM_COLS];
   logic signed [PROD_W-1:0] prod_in [NUM_COLS];
   logic signed [PAIR_W-1:0] pair_ff [2];
   logic signed [PAIR_W-1:0] pair_in [2];
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;

   // one full-precision product per matrix column
   always_comb begin
      for (int c = 0; c < NUM_COLS; c++) begin
         prod_in[c] = $signed(elem[c]) * $signed(vec[c]);
      end
   end

   // first adder level: two exact pair sums
   always_comb begin
      pair_in[0] = PAIR_W'(prod_ff[0]) + PAIR_W'(prod_ff[1]);
      pair_in[1] = PAIR_W'(prod_ff[2]) + PAIR_W'(prod_ff[3]);
   end

   // second adder level: exact four-term sum
   assign sum_in = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]);

   always_ff @(posedge clock) begin
      if (en.prod_en) begin
         prod_ff <= prod_in;
      end
      if (en.pair_en) begin
         pair_ff <= pair_in;
      end
      if (en.sum_en) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// ===== rtl/core/hmvt_merge.sv =====
module hmvt_merge import hmvt_pkg::*; (
   input  logic                    clock,
   input  logic                    load,
   input  logic signed [SUM_W-1:0] sum [NUM_COLS],
   output fix_vec_type             comp,
   output logic                    overflowed
);

   fix_vec_type               comp_ff;
   fix_vec_type               comp_in;
   logic                      ovf_ff;
   logic                      ovf_in;
   logic [NUM_COLS-1:0]       sat;
   logic [SUM_W-SAT_LSB-1:0]  top_bits [NUM_COLS];

   // scale down by the fraction width and clamp each lane to 32 bits
   always_comb begin
      for (int r = 0; r < NUM_COLS; r++) begin
         top_bits[r] = sum[r][SUM_W-1:SAT_LSB];
         sat[r]      = !((&top_bits[r]) || !(|top_bits[r]));
         if (sat[r]) begin
            comp_in[r] = sum[r][SUM_W-1] ? FIX_MIN : FIX_MAX;
         end else begin
            comp_in[r] = sum[r][SAT_LSB:FRAC_BITS];
         end
      end
      ovf_in = |sat;
   end

   // result register
   always_ff @(posedge clock) begin
      if (load) begin
         comp_ff <= comp_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign comp       = comp_ff;
   assign overflowed = ovf_ff;

endmodule

// ===== dv/homogeneous_matrix_vector_transform_top_test.sv =====
`timescale 1ns / 100ps

module homogeneous_matrix_vector_transform_top_test;
   import hmvt_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 2;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 192;
   localparam int HOLDOFF_CYCLES  = 400;
   localparam int QUIET_LIMIT     = 5000;
   localparam int DRAIN_CYCLES    = 8;

   localparam logic [FIX_W-1:0] ONE  = 32'h0001_0000;
   localparam logic [FIX_W-1:0] NEG1 = 32'hFFFF_0000;
   localparam logic [FIX_W-1:0] NIL  = 32'h0000_0000;

   typedef logic [NUM_REGS-1:0][REG_W-1:0] matrix_regs_t;

   // register map of the matrix
   typedef enum int {
      REG_COL_I_XY, REG_COL_I_ZW, REG_COL_J_XY, REG_COL_J_ZW,
      REG_COL_K_XY, REG_COL_K_ZW, REG_COL_T_XY, REG_COL_T_ZW
   } matrix_reg_e;

   typedef enum logic [2:0] {
      MAT_IDENTITY, MAT_TRANSLATE, MAT_ALL_MAX, MAT_ALL_MIN, MAT_RANDOM
   } matrix_preset_e;

   typedef struct packed {
      fix_vec_type comp;
      logic        overflowed;
   } xform_t;

   typedef struct packed {
      matrix_preset_e   preset;
      logic [FIX_W-1:0] in_x, in_y, in_z, in_w;
      logic             check;
      logic [FIX_W-1:0] exp_x, exp_y, exp_z, exp_w;
      logic             exp_ovf;
   } directed_row_t;

   // directed vectors; rows with check low are predicted
   localparam int N_DIRECTED = 22;
   localparam directed_row_t [0:N_DIRECTED-1] DIRECTED_ROWS = '{
      '{MAT_IDENTITY, NIL, NIL, NIL, NIL, 1'b1, NIL, NIL, NIL, NIL, 1'b0},
      '{MAT_IDENTITY, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX,
        1'b1, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, 1'b0},
      '{MAT_IDENTITY, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN,
        1'b1, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, 1'b0},
      '{MAT_IDENTITY, ONE, 32'h0002_0000, 32'hFFFD_0000, ONE,
        1'b1, ONE, 32'h0002_0000, 32'hFFFD_0000, ONE, 1'b0},
      '{MAT_IDENTITY, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_0000, NIL,
        1'b1, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_0000, NIL, 1'b0},
      '{MAT_IDENTITY, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
        1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0},
      '{MAT_TRANSLATE, ONE, ONE, ONE, ONE, 1'b0, NIL, NIL, NIL, NIL, 1'b0},
      '{MAT_TRANSLATE, ONE, ONE, ONE, NIL, 1'b0, NIL, NIL, NIL, NIL, 1'b0},
      '{MAT_TRANSLATE, FIX_MAX, NIL, NIL, ONE, 1'b0, NIL, NIL, NIL, NIL, 1'b0},
      '{MAT_TRANSLATE, FIX_MIN, FIX_MIN, NIL, ONE, 1'b0, NIL, NIL, NIL, NIL, 1'b0},
      '{MAT_ALL_MAX, ONE, ONE, ONE, ONE,
        1'b1, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, 1'b1},
      '{MAT_ALL_MAX, NEG1, NEG1, NEG1, NEG1,
        1'b1, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, 1'b1},
      '{MAT_ALL_MAX, NIL, NIL, NIL, NIL, 1'b1, NIL, NIL, NIL, NIL, 1'b0},
      '{MAT_ALL_MAX, FIX_MAX, FIX_MIN, NIL, NIL, 1'b0, NIL, NIL, NIL, NIL, 1'b0},
      '{MAT_ALL_MAX, 32'h0000_0001, NIL, NIL, NIL, 1'b0, NIL, NIL, NIL, NIL, 1'b0},
      '{MAT_ALL_MAX, 32'hFFFF_FFFF, NIL, NIL, NIL, 1'b0, NIL, NIL, NIL, NIL, 1'b0},
      '{MAT_ALL_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN,
        1'b1, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, 1'b1},
      '{MAT_ALL_MIN, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX,
        1'b1, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, 1'b1},
      '{MAT_ALL_MIN, ONE, NIL, NIL, NIL,
        1'b1, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, 1'b0},
      '{MAT_ALL_MIN, NEG1, NIL, NIL, NIL,
        1'b1, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, 1'b1},
      '{MAT_ALL_MIN, ONE, NEG1, ONE, NEG1, 1'b1, NIL, NIL, NIL, NIL, 1'b0},
      '{MAT_ALL_MIN, 32'h0000_0001, NIL, NIL, NIL, 1'b0, NIL, NIL, NIL, NIL, 1'b0}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [REG_IDX_W-1:0] csr_index;
   logic [REG_W-1:0]     csr_wdata;

   hmvt_req_if req_ch ();
   hmvt_rsp_if rsp_ch ();

   homogeneous_matrix_vector_transform_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the matrix and the pending transformed vectors
   matrix_regs_t matrix_regs;
   xform_t       pending_vectors [$];

   int req_idle_pct;
   int rsp_stall_pct;
   int holdoff_requests;
   int error_count;
   int vectors_sent;
   int vectors_checked;
   int saturated_results;
   int matrix_loads;

   string comp_names [4] = '{"out_x", "out_y", "out_z", "out_w"};

   always #(CLK_PERIOD / 2) clock = ~clock;

   // out_r = sum over columns of elem(c, r) * v[c], floor-shifted and clamped
   function automatic xform_t transform_vector(input fix_vec_type vec);
      xform_t                  res;
      logic [REG_W-1:0]        col_reg;
      logic signed [FIX_W-1:0] elem;
      logic signed [FIX_W-1:0] comp;
      logic signed [SUM_W-1:0] acc;
      logic signed [SUM_W-1:0] shifted;
      res.overflowed = 1'b0;
      for (int r = 0; r < NUM_COLS; r++) begin
         acc = '0;
         for (int c = 0; c < NUM_COLS; c++) begin
            col_reg = matrix_regs[2 * c + r / 2];
            elem    = (r % 2) ? col_reg[REG_W-1:FIX_W] : col_reg[FIX_W-1:0];
            comp    = vec[c];
            acc     = acc + elem * comp;
         end
         shifted = acc >>> FRAC_BITS;
         if (&shifted[SUM_W-1:FIX_W-1] || ~|shifted[SUM_W-1:FIX_W-1]) begin
            res.comp[r] = shifted[FIX_W-1:0];
         end else begin
            res.comp[r]    = shifted[SUM_W-1] ? FIX_MIN : FIX_MAX;
            res.overflowed = 1'b1;
         end
      end
      return res;
   endfunction

   // mix of extremes, small Q16.16 values and raw random words
   function automatic logic [FIX_W-1:0] rand_fix();
      logic [FIX_W-1:0] val;
      case ($urandom_range(9))
         0: val = NIL;
         1: val = ONE;
         2: val = NEG1;
         3: val = FIX_MAX;
         4: val = FIX_MIN;
         5, 6, 7: val = FIX_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
         default: val = $urandom;
      endcase
      return val;
   endfunction

   // mostly positions and directions, some arbitrary w
   function automatic fix_vec_type rand_vector();
      fix_vec_type vec;
      for (int c = 0; c < NUM_COLS - 1; c++) vec[c] = rand_fix();
      case ($urandom_range(9))
         0, 1, 2, 3: vec[NUM_COLS-1] = ONE;
         4, 5, 6: vec[NUM_COLS-1] = NIL;
         default: vec[NUM_COLS-1] = rand_fix();
      endcase
      return vec;
   endfunction

   function automatic matrix_regs_t build_matrix(input matrix_preset_e preset);
      matrix_regs_t regs;
      case (preset)
         MAT_TRANSLATE: begin
            regs = CFG_RESET;
            regs[REG_COL_T_XY] = {32'hFFFE_0000, 32'h0003_0000};
            regs[REG_COL_T_ZW] = {ONE, 32'h0000_8000};
         end
         MAT_ALL_MAX: begin
            for (int i = 0; i < NUM_REGS; i++) regs[i] = {FIX_MAX, FIX_MAX};
         end
         MAT_ALL_MIN: begin
            for (int i = 0; i < NUM_REGS; i++) regs[i] = {FIX_MIN, FIX_MIN};
         end
         MAT_RANDOM: begin
            for (int i = 0; i < NUM_REGS; i++) regs[i] = {rand_fix(), rand_fix()};
         end
         default: regs = CFG_RESET;
      endcase
      return regs;
   endfunction

   // called at a falling edge; drops valid, drains, then writes every register
   task automatic load_matrix(input matrix_regs_t regs);
      req_ch.valid <= 1'b0;
      while (pending_vectors.size() != 0) @(negedge clock);
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= REG_IDX_W'(i);
         csr_wdata   <= regs[i];
         matrix_regs[i] = regs[i];
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
      matrix_loads++;
   endtask

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_vector(input fix_vec_type vec, input xform_t want);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.in_x  <= vec[0];
      req_ch.in_y  <= vec[1];
      req_ch.in_z  <= vec[2];
      req_ch.in_w  <= vec[3];
      do @(posedge clock); while (!req_ch.ready);
      pending_vectors.push_back(want);
      vectors_sent++;
      @(negedge clock);
   endtask

   // result side: random stalls plus a long hold when requested
   initial begin
      int hold_left;
      int holds_served;
      hold_left     = 0;
      holds_served  = 0;
      rsp_ch.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != holdoff_requests) begin
            holds_served = holdoff_requests;
            hold_left    = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      xform_t got;
      xform_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.comp       = {rsp_ch.out_w, rsp_ch.out_z, rsp_ch.out_y, rsp_ch.out_x};
         got.overflowed = rsp_ch.overflowed;
         if (got.overflowed === 1'b1) saturated_results++;
         if (pending_vectors.size() == 0) begin
            $error("result beat with nothing pending: %h", got);
            error_count++;
         end else begin
            want = pending_vectors.pop_front();
            vectors_checked++;
            for (int r = 0; r < NUM_COLS; r++) begin
               if (got.comp[r] !== want.comp[r]) begin
                  $error("%s mismatch: expected %h, got %h",
                         comp_names[r], want.comp[r], got.comp[r]);
                  error_count++;
               end
            end
            if (got.overflowed !== want.overflowed) begin
               $error("overflowed mismatch: expected %b, got %b",
                      want.overflowed, got.overflowed);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("timeout after %0d quiet cycles", QUIET_LIMIT);
      $display("homogeneous_matrix_vector_transform_top_test NOT OK");
      $finish;
   end

   initial begin
      directed_row_t  row;
      fix_vec_type    vec;
      xform_t         want;
      matrix_preset_e loaded;

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.in_x       = '0;
      req_ch.in_y       = '0;
      req_ch.in_z       = '0;
      req_ch.in_w       = '0;
      csr_wr_en         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_idle_pct      = 35;
      rsp_stall_pct     = 35;
      holdoff_requests  = 0;
      error_count       = 0;
      vectors_sent      = 0;
      vectors_checked   = 0;
      saturated_results = 0;
      matrix_loads      = 0;
      matrix_regs       = CFG_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, starting on the identity left by reset
      loaded = MAT_IDENTITY;
      for (int i = 0; i < N_DIRECTED; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.preset != loaded) begin
            loaded = row.preset;
            load_matrix(build_matrix(loaded));
         end
         vec = {row.in_w, row.in_z, row.in_y, row.in_x};
         if (row.check) begin
            want.comp       = {row.exp_w, row.exp_z, row.exp_y, row.exp_x};
            want.overflowed = row.exp_ovf;
         end else begin
            want = transform_vector(vec);
         end
         send_vector(vec, want);
      end

      // random phases: new matrix and idle pattern each
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_matrix(build_matrix(MAT_RANDOM));
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 75; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 75; end
            default: begin req_idle_pct = 35; rsp_stall_pct = 35; end
         endcase
         // back up the pipeline while the input keeps offering beats
         if (phase == 0) holdoff_requests <= holdoff_requests + 1;
         repeat (ITEMS_PER_PHASE) begin
            vec = rand_vector();
            send_vector(vec, transform_vector(vec));
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_vectors.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("checked %0d of %0d vectors over %0d matrix loads, %0d saturated",
               vectors_checked, vectors_sent, matrix_loads, saturated_results);
      $display("idle mixes: none, input 75%%, output 75%%, both 35%%, one %0d-cycle hold",
               HOLDOFF_CYCLES);
      if (error_count == 0)
         $display("homogeneous_matrix_vector_transform_top_test OK");
      else
         $display("homogeneous_matrix_vector_transform_top_test NOT OK");
      $finish;
   end

endmodule

// ===== homogeneous_matrix_vector_transform_top.f =====
rtl/core/hmvt_pkg.sv
rtl/core/hmvt_if.sv
rtl/core/hmvt_lane.sv
rtl/core/hmvt_merge.sv
rtl/core/homogeneous_matrix_vector_transform_top.sv
dv/homogeneous_matrix_vector_transform_top_test.sv
